### rtl/core/gmfn_pkg.sv
// ----------------------------------------------------------------------------
// gmfn_pkg
// Shared types and constants of the posture mode filter and item navigator.
// ----------------------------------------------------------------------------
package gmfn_pkg;

   localparam int HISTORY_DEPTH_DEF = 16;
   localparam int CLASS_COUNT_DEF   = 8;

   localparam int CODE_W = 3;
   localparam int IDX_W  = 8;
   localparam int STEP_W = 2;
   localparam int CDC_W  = 8;

   // register reset values
   localparam logic [4:0] WINDOW_LENGTH_RST    = 5'd10;
   localparam logic [5:0] COOLDOWN_FRAMES_RST  = 6'd30;
   localparam logic [7:0] ITEM_COUNT_RST       = 8'd0;
   localparam logic [2:0] SWIPE_LEFT_CODE_RST  = 3'd2;
   localparam logic [2:0] SWIPE_RIGHT_CODE_RST = 3'd3;

   // register indexes on the csr port
   localparam logic [2:0] REG_WINDOW_LENGTH    = 3'd0;
   localparam logic [2:0] REG_COOLDOWN_FRAMES  = 3'd1;
   localparam logic [2:0] REG_ITEM_COUNT       = 3'd2;
   localparam logic [2:0] REG_SWIPE_LEFT_CODE  = 3'd3;
   localparam logic [2:0] REG_SWIPE_RIGHT_CODE = 3'd4;

   localparam logic [STEP_W-1:0] STEP_NONE = 2'd0;
   localparam logic [STEP_W-1:0] STEP_FWD  = 2'd1;
   localparam logic [STEP_W-1:0] STEP_BACK = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN,
      ST_DECIDE
   } ctrl_state_type;

   // controls from the sequencer to the vote unit
   typedef struct packed {
      logic              start;
      logic              acc;
      logic [CODE_W-1:0] code;
   } vote_ctl_type;

   typedef struct packed {
      logic [4:0] window_length;
      logic [5:0] cooldown_frames;
      logic [7:0] item_count;
      logic [2:0] swipe_left_code;
      logic [2:0] swipe_right_code;
   } cfg_type;

endpackage

### rtl/core/gmfn_hist_ram.sv
// ----------------------------------------------------------------------------
// gmfn_hist_ram
// Posture code history: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gmfn_hist_ram
   import gmfn_pkg::*;
#(
   parameter int DEPTH = HISTORY_DEPTH_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [CODE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [CODE_W-1:0] rd_data
);

   logic [CODE_W-1:0] mem [DEPTH];
   logic [CODE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/gmfn_vote.sv
// ----------------------------------------------------------------------------
// gmfn_vote
// Per-class vote counters with a running mode, ties going to the lower class.
// ----------------------------------------------------------------------------
module gmfn_vote
   import gmfn_pkg::*;
#(
   parameter int DEPTH       = HISTORY_DEPTH_DEF,
   parameter int CLASS_COUNT = CLASS_COUNT_DEF
) (
   input  logic              clock,
   input  vote_ctl_type      ctl,
   output logic [CODE_W-1:0] mode_code
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = $clog2(CLASS_COUNT);

   logic [CW-1:0] counts_ff [CLASS_COUNT];
   logic [CW-1:0] counts_in [CLASS_COUNT];
   logic [KW-1:0] best_ff, best_in;
   logic [CW-1:0] best_cnt_ff, best_cnt_in;
   logic [4:0]    code_ext;
   logic [KW-1:0] cls;
   logic [CW-1:0] bumped;
   logic [4:0]    best_ext;

   // codes past the last class vote as the last class
   always_comb begin
      code_ext = {2'b00, ctl.code};
      if (code_ext >= 5'(CLASS_COUNT)) begin
         cls = KW'(CLASS_COUNT - 1);
      end else begin
         cls = code_ext[KW-1:0];
      end
   end

   assign bumped = counts_ff[cls] + 1'b1;

   // counts only grow by one, so the mode can be tracked as they change
   always_comb begin
      counts_in   = counts_ff;
      best_in     = best_ff;
      best_cnt_in = best_cnt_ff;
      if (ctl.start) begin
         for (int i = 0; i < CLASS_COUNT; i++) begin
            counts_in[i] = '0;
         end
         counts_in[cls] = CW'(1);
         best_in        = cls;
         best_cnt_in    = CW'(1);
      end else if (ctl.acc) begin
         counts_in[cls] = bumped;
         if (bumped > best_cnt_ff) begin
            best_in     = cls;
            best_cnt_in = bumped;
         end else if (bumped == best_cnt_ff && cls < best_ff) begin
            best_in = cls;
         end
      end
   end

   always_ff @(posedge clock) begin
      counts_ff   <= counts_in;
      best_ff     <= best_in;
      best_cnt_ff <= best_cnt_in;
   end

   assign best_ext  = 5'(best_ff);
   assign mode_code = best_ext[CODE_W-1:0];

endmodule

### rtl/core/gmfn_ctrl.sv
// ----------------------------------------------------------------------------
// gmfn_ctrl
// Frame sequencer: history pointers, window walk, cooldown, item index and
// the result register.
// ----------------------------------------------------------------------------
module gmfn_ctrl
   import gmfn_pkg::*;
#(
   parameter int DEPTH = HISTORY_DEPTH_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CODE_W-1:0] req_posture_code,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CODE_W-1:0] rsp_filtered_code,
   output logic [IDX_W-1:0]  rsp_item_index,
   output logic [STEP_W-1:0] rsp_step_taken,
   output logic              rsp_cooldown_busy,
   output logic              ram_wr_en,
   output logic [AW-1:0]     ram_wr_addr,
   output logic [CODE_W-1:0] ram_wr_data,
   output logic              ram_rd_en,
   output logic [AW-1:0]     ram_rd_addr,
   input  logic [CODE_W-1:0] ram_rd_data,
   output vote_ctl_type      vote_ctl,
   input  logic [CODE_W-1:0] mode_code
);

   localparam int FW = $clog2(DEPTH + 1);
   localparam int LW = (FW > 5) ? FW : 5;

   ctrl_state_type    state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [LW-1:0]     remain_ff, remain_in;
   logic              rd_pend_ff, rd_pend_in;
   logic [CODE_W-1:0] raw_ff, raw_in;
   logic              cd_idle_ff, cd_idle_in;
   logic [CDC_W-1:0]  cd_count_ff, cd_count_in;
   logic [IDX_W-1:0]  index_ff, index_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_filt_ff, rsp_filt_in;
   logic [IDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [STEP_W-1:0] rsp_step_ff, rsp_step_in;
   logic              rsp_busy_ff, rsp_busy_in;

   logic              accept;
   logic              fire;
   logic              is_read;
   logic [FW-1:0]     fill_new;
   logic [LW-1:0]     win_eff;
   logic [LW-1:0]     fill_ext;
   logic [LW-1:0]     win_n;
   logic [CDC_W-1:0]  cd_inc;
   logic              fwd, back;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign fire   = (state_ff == ST_DECIDE) && !(rsp_valid_ff && rsp_stall);

   // window size: zero counts as one, never past the codes held
   always_comb begin
      fill_new = (fill_ff < FW'(DEPTH)) ? fill_ff + 1'b1 : fill_ff;
      win_eff  = (cfg.window_length == 5'd0) ? LW'(1) : LW'(cfg.window_length);
      fill_ext = LW'(fill_new);
      win_n    = (win_eff < fill_ext) ? win_eff : fill_ext;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (win_n > LW'(1)) ? ST_READ : ST_DECIDE;
            end
         end
         ST_READ: begin
            if (remain_ff == LW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state outputs
   always_comb begin
      req_stall = 1'b1;
      is_read   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_READ: begin
            is_read = 1'b1;
         end
         ST_DRAIN, ST_DECIDE: begin
            req_stall = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // history write and walk over the older codes, newest first
   assign ram_wr_en   = accept;
   assign ram_wr_addr = head_ff;
   assign ram_wr_data = req_posture_code;
   assign ram_rd_en   = is_read;
   assign ram_rd_addr = rd_ptr_ff;
   assign rd_pend_in  = is_read;

   assign vote_ctl.start = accept;
   assign vote_ctl.acc   = rd_pend_ff;
   assign vote_ctl.code  = accept ? req_posture_code : ram_rd_data;

   always_comb begin
      head_in   = head_ff;
      fill_in   = fill_ff;
      rd_ptr_in = rd_ptr_ff;
      remain_in = remain_ff;
      raw_in    = raw_ff;
      if (accept) begin
         head_in   = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         fill_in   = fill_new;
         rd_ptr_in = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;
         remain_in = win_n - 1'b1;
         raw_in    = req_posture_code;
      end else if (is_read) begin
         rd_ptr_in = (rd_ptr_ff == '0) ? AW'(DEPTH - 1) : rd_ptr_ff - 1'b1;
         remain_in = remain_ff - 1'b1;
      end
   end

   // cooldown advances on transfer, a step restarts it at decision time
   assign cd_inc = cd_count_ff + 1'b1;
   assign fwd    = cd_idle_ff && (mode_code == cfg.swipe_left_code)
                   && (raw_ff == cfg.swipe_right_code);
   assign back   = cd_idle_ff && !fwd && (mode_code == cfg.swipe_right_code)
                   && (raw_ff == cfg.swipe_left_code);

   always_comb begin
      cd_idle_in   = cd_idle_ff;
      cd_count_in  = cd_count_ff;
      index_in     = index_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_filt_in  = rsp_filt_ff;
      rsp_index_in = rsp_index_ff;
      rsp_step_in  = rsp_step_ff;
      rsp_busy_in  = rsp_busy_ff;
      if (accept && !cd_idle_ff) begin
         if (cd_inc > {2'b00, cfg.cooldown_frames}) begin
            cd_idle_in  = 1'b1;
            cd_count_in = '0;
         end else begin
            cd_count_in = cd_inc;
         end
      end
      if (fire) begin
         rsp_step_in = STEP_NONE;
         if (fwd) begin
            rsp_step_in = STEP_FWD;
            if (({1'b0, index_ff} + 9'd1) < {1'b0, cfg.item_count}) begin
               index_in = index_ff + 1'b1;
            end
         end else if (back) begin
            rsp_step_in = STEP_BACK;
            if (index_ff != '0) begin
               index_in = index_ff - 1'b1;
            end
         end
         if (fwd || back) begin
            cd_idle_in  = 1'b0;
            cd_count_in = '0;
         end
         rsp_valid_in = 1'b1;
         rsp_filt_in  = mode_code;
         rsp_index_in = index_in;
         rsp_busy_in  = !cd_idle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         cd_idle_ff   <= 1'b1;
         cd_count_ff  <= '0;
         index_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rd_pend_ff   <= rd_pend_in;
         cd_idle_ff   <= cd_idle_in;
         cd_count_ff  <= cd_count_in;
         index_ff     <= index_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      remain_ff    <= remain_in;
      raw_ff       <= raw_in;
      rsp_filt_ff  <= rsp_filt_in;
      rsp_index_ff <= rsp_index_in;
      rsp_step_ff  <= rsp_step_in;
      rsp_busy_ff  <= rsp_busy_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered_code = rsp_filt_ff;
   assign rsp_item_index    = rsp_index_ff;
   assign rsp_step_taken    = rsp_step_ff;
   assign rsp_cooldown_busy = rsp_busy_ff;

`ifndef SYNTH
   a_step_starts_cooldown: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_step_ff != STEP_NONE) |-> rsp_busy_ff)
      else $error("step reported without a running cooldown");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(DEPTH))
      else $error("history fill past depth");

   a_read_has_work: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (remain_ff != '0))
      else $error("window walk with nothing left to read");

   a_decide_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) && !rsp_stall |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("decision did not load the result register");
`endif

endmodule

### rtl/core/gesture_mode_filter_navigator_top.sv
// ----------------------------------------------------------------------------
// gesture_mode_filter_navigator_top
// Posture mode filter over a sliding window of frames and swipe-driven
// item navigator, with an APB-style register port.
// ----------------------------------------------------------------------------
// n = min(window_length (zero as one), codes held); after a frame transfer
//   the walk reads the n-1 older codes through the single history read port
//   (READ, DRAIN, both skipped when n is 1), then DECIDE loads the result
//   register; a new frame is taken only in IDLE, once that result is loaded
// reset: synchronous; the head pointer, fill, cooldown and index clear at once,
//   the history memory is not cleared and no clearing pass runs
module gesture_mode_filter_navigator_top
   import gmfn_pkg::*;
#(
   parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
   parameter int CLASS_COUNT   = CLASS_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [CODE_W-1:0] req_posture_code,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CODE_W-1:0] rsp_filtered_code,
   output logic [IDX_W-1:0]  rsp_item_index,
   output logic [STEP_W-1:0] rsp_step_taken,
   output logic              rsp_cooldown_busy,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   localparam int AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

   cfg_type           cfg_ff, cfg_in;
   logic              csr_wr;
   logic [2:0]        reg_idx;

   logic              ram_wr_en;
   logic [AW-1:0]     ram_wr_addr;
   logic [CODE_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [AW-1:0]     ram_rd_addr;
   logic [CODE_W-1:0] ram_rd_data;
   vote_ctl_type      vote_ctl;
   logic [CODE_W-1:0] mode_code;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign reg_idx = paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         case (reg_idx)
            REG_WINDOW_LENGTH:    cfg_in.window_length    = pwdata[4:0];
            REG_COOLDOWN_FRAMES:  cfg_in.cooldown_frames  = pwdata[5:0];
            REG_ITEM_COUNT:       cfg_in.item_count       = pwdata[7:0];
            REG_SWIPE_LEFT_CODE:  cfg_in.swipe_left_code  = pwdata[2:0];
            REG_SWIPE_RIGHT_CODE: cfg_in.swipe_right_code = pwdata[2:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_WINDOW_LENGTH:    prdata = 32'(cfg_ff.window_length);
         REG_COOLDOWN_FRAMES:  prdata = 32'(cfg_ff.cooldown_frames);
         REG_ITEM_COUNT:       prdata = 32'(cfg_ff.item_count);
         REG_SWIPE_LEFT_CODE:  prdata = 32'(cfg_ff.swipe_left_code);
         REG_SWIPE_RIGHT_CODE: prdata = 32'(cfg_ff.swipe_right_code);
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length    <= WINDOW_LENGTH_RST;
         cfg_ff.cooldown_frames  <= COOLDOWN_FRAMES_RST;
         cfg_ff.item_count       <= ITEM_COUNT_RST;
         cfg_ff.swipe_left_code  <= SWIPE_LEFT_CODE_RST;
         cfg_ff.swipe_right_code <= SWIPE_RIGHT_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gmfn_hist_ram #(
      .DEPTH (HISTORY_DEPTH),
      .AW    (AW)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   gmfn_vote #(
      .DEPTH       (HISTORY_DEPTH),
      .CLASS_COUNT (CLASS_COUNT)
   ) u_vote (
      .clock     (clock),
      .ctl       (vote_ctl),
      .mode_code (mode_code)
   );

   gmfn_ctrl #(
      .DEPTH (HISTORY_DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_posture_code  (req_posture_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_filtered_code (rsp_filtered_code),
      .rsp_item_index    (rsp_item_index),
      .rsp_step_taken    (rsp_step_taken),
      .rsp_cooldown_busy (rsp_cooldown_busy),
      .ram_wr_en         (ram_wr_en),
      .ram_wr_addr       (ram_wr_addr),
      .ram_wr_data       (ram_wr_data),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .vote_ctl          (vote_ctl),
      .mode_code         (mode_code)
   );

endmodule

### sim/gmfn_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gmfn_frame_checker
// Watches the frame, result and register ports of the posture mode filter,
// keeps its own copy of the history, cooldown and item index, predicts each
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module gmfn_frame_checker
   import gmfn_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [CODE_W-1:0] req_posture_code,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [CODE_W-1:0] rsp_filtered_code,
   input  logic [IDX_W-1:0]  rsp_item_index,
   input  logic [STEP_W-1:0] rsp_step_taken,
   input  logic              rsp_cooldown_busy,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [4:0]        paddr,
   input  logic [31:0]       pwdata,
   input  logic              pready,
   output int                mismatches,
   output int                expected_left
);

   localparam int DEPTH         = HISTORY_DEPTH_DEF;
   localparam int CLASSES       = CLASS_COUNT_DEF;
   localparam int PENDING_DEPTH = 8;

   typedef struct packed {
      logic [CODE_W-1:0] filtered_code;
      logic [IDX_W-1:0]  item_index;
      logic [STEP_W-1:0] step_taken;
      logic              cooldown_busy;
   } frame_result_type;

   cfg_type           cfg;
   logic [CODE_W-1:0] code_window [DEPTH];
   int                held_codes;
   int                write_slot;
   bit                cooldown_idle;
   int                cooldown_count;
   int                selected_index;
   frame_result_type  awaited_results [PENDING_DEPTH];
   int                take_slot;
   int                put_slot;
   int                awaited_count;

   function automatic int voting_class(input int code);
      return (code >= CLASSES) ? CLASSES - 1 : code;
   endfunction

   // cooldown first, then push and vote, then a possible step
   function automatic frame_result_type next_frame_result(input logic [CODE_W-1:0] raw);
      int               tally [CLASSES];
      int               span;
      int               pos;
      int               best;
      int               best_count;
      logic [STEP_W-1:0] step;
      frame_result_type res;

      if (!cooldown_idle) begin
         cooldown_count++;
         if (cooldown_count > int'(cfg.cooldown_frames)) begin
            cooldown_idle  = 1'b1;
            cooldown_count = 0;
         end
      end

      code_window[write_slot] = raw;
      write_slot = (write_slot + 1) % DEPTH;
      if (held_codes < DEPTH) held_codes++;

      span = (cfg.window_length == 0) ? 1 : int'(cfg.window_length);
      if (span > held_codes) span = held_codes;
      foreach (tally[k]) tally[k] = 0;
      pos = write_slot;
      for (int k = 0; k < span; k++) begin
         pos = (pos == 0) ? DEPTH - 1 : pos - 1;
         tally[voting_class(int'(code_window[pos]))]++;
      end
      best       = 0;
      best_count = 0;
      for (int k = 0; k < CLASSES; k++) begin
         if (tally[k] > best_count) begin
            best_count = tally[k];
            best       = k;
         end
      end

      step = STEP_NONE;
      if (cooldown_idle) begin
         if (best == int'(cfg.swipe_left_code) && raw == cfg.swipe_right_code &&
             voting_class(int'(raw)) == voting_class(int'(cfg.swipe_right_code))) begin
            step = STEP_FWD;
            if (selected_index + 1 < int'(cfg.item_count)) selected_index++;
         end else if (best == int'(cfg.swipe_right_code) && raw == cfg.swipe_left_code) begin
            step = STEP_BACK;
            if (selected_index > 0) selected_index--;
         end
         if (step != STEP_NONE) begin
            cooldown_idle  = 1'b0;
            cooldown_count = 0;
         end
      end

      res.filtered_code = best[CODE_W-1:0];
      res.item_index    = selected_index[IDX_W-1:0];
      res.step_taken    = step;
      res.cooldown_busy = !cooldown_idle;
      return res;
   endfunction

   task automatic flag_mismatch(input string what, input int want, input int got);
      $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch_ports
      frame_result_type want;

      if (reset) begin
         cfg.window_length    = WINDOW_LENGTH_RST;
         cfg.cooldown_frames  = COOLDOWN_FRAMES_RST;
         cfg.item_count       = ITEM_COUNT_RST;
         cfg.swipe_left_code  = SWIPE_LEFT_CODE_RST;
         cfg.swipe_right_code = SWIPE_RIGHT_CODE_RST;
         held_codes     = 0;
         write_slot     = 0;
         cooldown_idle  = 1'b1;
         cooldown_count = 0;
         selected_index = 0;
         take_slot      = 0;
         put_slot       = 0;
         awaited_count  = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_WINDOW_LENGTH:    cfg.window_length    = pwdata[4:0];
               REG_COOLDOWN_FRAMES:  cfg.cooldown_frames  = pwdata[5:0];
               REG_ITEM_COUNT:       cfg.item_count       = pwdata[7:0];
               REG_SWIPE_LEFT_CODE:  cfg.swipe_left_code  = pwdata[2:0];
               REG_SWIPE_RIGHT_CODE: cfg.swipe_right_code = pwdata[2:0];
               default: ;
            endcase
         end
         // older frames leave before the one arriving on this edge is added
         if (rsp_valid && !rsp_stall) begin
            if (awaited_count == 0) begin
               flag_mismatch("result with none outstanding", 0, 1);
            end else begin
               want          = awaited_results[take_slot];
               take_slot     = (take_slot + 1) % PENDING_DEPTH;
               awaited_count = awaited_count - 1;
               if (rsp_filtered_code !== want.filtered_code)
                  flag_mismatch("filtered_code", int'(want.filtered_code),
                                int'(rsp_filtered_code));
               if (rsp_item_index !== want.item_index)
                  flag_mismatch("item_index", int'(want.item_index), int'(rsp_item_index));
               if (rsp_step_taken !== want.step_taken)
                  flag_mismatch("step_taken", int'(want.step_taken), int'(rsp_step_taken));
               if (rsp_cooldown_busy !== want.cooldown_busy)
                  flag_mismatch("cooldown_busy", int'(want.cooldown_busy),
                                int'(rsp_cooldown_busy));
            end
         end
         if (req_valid && !req_stall) begin
            if (awaited_count == PENDING_DEPTH) begin
               flag_mismatch("frames outstanding", PENDING_DEPTH, awaited_count + 1);
            end else begin
               awaited_results[put_slot] = next_frame_result(req_posture_code);
               put_slot      = (put_slot + 1) % PENDING_DEPTH;
               awaited_count = awaited_count + 1;
            end
         end
      end
      expected_left = awaited_count;
   end

endmodule

### sim/gesture_mode_filter_navigator_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_mode_filter_navigator_top_test
// Drives posture frames and register settings into the mode filter and
// navigator: a short directed part for the corner cases, then phases of
// swipe gestures mixed with noise under varying settings and flow control.
// The frame checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module gesture_mode_filter_navigator_top_test;
   import gmfn_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_FRAMES  = 115;
   localparam int RANDOM_PHASES = 6;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [CODE_W-1:0] req_posture_code = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [CODE_W-1:0] rsp_filtered_code;
   logic [IDX_W-1:0]  rsp_item_index;
   logic [STEP_W-1:0] rsp_step_taken;
   logic              rsp_cooldown_busy;
   logic              psel             = 1'b0;
   logic              penable          = 1'b0;
   logic              pwrite           = 1'b0;
   logic [4:0]        paddr            = '0;
   logic [31:0]       pwdata           = '0;
   logic [31:0]       prdata;
   logic              pready;

   int mismatches;
   int expected_left;
   int gap_pct        = 0;
   int stall_pct      = 0;
   int hold_asks      = 0;
   int hold_done      = 0;
   int hold_left      = 0;
   int cycle_count    = 0;
   int phase_frames   = 0;

   logic [4:0]        cur_window = WINDOW_LENGTH_RST;
   logic [CODE_W-1:0] cur_left   = SWIPE_LEFT_CODE_RST;
   logic [CODE_W-1:0] cur_right  = SWIPE_RIGHT_CODE_RST;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   gesture_mode_filter_navigator_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_posture_code  (req_posture_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_filtered_code (rsp_filtered_code),
      .rsp_item_index    (rsp_item_index),
      .rsp_step_taken    (rsp_step_taken),
      .rsp_cooldown_busy (rsp_cooldown_busy),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   gmfn_frame_checker frame_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_posture_code  (req_posture_code),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_filtered_code (rsp_filtered_code),
      .rsp_item_index    (rsp_item_index),
      .rsp_step_taken    (rsp_step_taken),
      .rsp_cooldown_busy (rsp_cooldown_busy),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .pready            (pready),
      .mismatches        (mismatches),
      .expected_left     (expected_left)
   );

   // result side: random stall, or a long hold-off when one is asked for
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (hold_done != hold_asks) begin
         rsp_stall <= 1'b1;
         hold_done++;
         hold_left = LONG_HOLD;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic csr_write(input logic [2:0] reg_index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // upper data bits carry junk, the block keeps only the register width
   task automatic apply_settings(input logic [4:0] window, input logic [5:0] cooldown,
                                 input logic [7:0] items, input logic [CODE_W-1:0] left,
                                 input logic [CODE_W-1:0] right);
      csr_write(REG_WINDOW_LENGTH,    {8'($urandom_range(255)), 19'd0, window});
      csr_write(REG_COOLDOWN_FRAMES,  {8'($urandom_range(255)), 18'd0, cooldown});
      csr_write(REG_ITEM_COUNT,       {8'($urandom_range(255)), 16'd0, items});
      csr_write(REG_SWIPE_LEFT_CODE,  {8'($urandom_range(255)), 21'd0, left});
      csr_write(REG_SWIPE_RIGHT_CODE, {8'($urandom_range(255)), 21'd0, right});
      cur_window = window;
      cur_left   = left;
      cur_right  = right;
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_left != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic push_frame(input logic [CODE_W-1:0] code);
      while ($urandom_range(99) < gap_pct) begin
         req_valid        <= 1'b0;
         req_posture_code <= CODE_W'($urandom);
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_posture_code <= code;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      phase_frames++;
   endtask

   // a run of one swipe code that fills at least half of the window, then usually the other
   task automatic push_gesture();
      logic [CODE_W-1:0] lead;
      logic [CODE_W-1:0] tail;
      int                span;
      int                run;

      if ($urandom_range(1)) begin
         lead = cur_left;
         tail = cur_right;
      end else begin
         lead = cur_right;
         tail = cur_left;
      end
      span = (cur_window == 0) ? 1 : int'(cur_window);
      run  = $urandom_range(span, (span + 1) / 2);
      repeat (run) push_frame(lead);
      if ($urandom_range(7) != 0) push_frame(tail);
   endtask

   task automatic push_noise();
      repeat ($urandom_range(4, 1)) push_frame(CODE_W'($urandom));
   endtask

   initial begin
      logic [4:0]        window;
      logic [5:0]        cooldown;
      logic [7:0]        items;
      logic [CODE_W-1:0] left;
      logic [CODE_W-1:0] right;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: window longer than the codes held, forward step on
      // an empty item list, then every code value
      push_frame(3'd2);
      push_frame(3'd2);
      push_frame(3'd2);
      push_frame(3'd2);
      push_frame(3'd3);
      push_frame(3'd7);
      push_frame(3'd0);
      push_frame(3'd5);
      push_frame(3'd1);
      push_frame(3'd6);
      push_frame(3'd4);
      drain_results();

      // zero window votes on the newest code alone, equal swipe codes step
      // forward, no cooldown
      apply_settings(5'd0, 6'd0, 8'd255, 3'd5, 3'd5);
      repeat (6) push_frame(3'd5);
      push_frame(3'd0);
      push_frame(3'd7);
      drain_results();

      // item count lowered below the index: forward holds, back decrements
      apply_settings(5'd3, 6'd0, 8'd4, 3'd1, 3'd6);
      push_frame(3'd1);
      push_frame(3'd1);
      push_frame(3'd6);
      push_frame(3'd6);
      push_frame(3'd6);
      push_frame(3'd1);
      drain_results();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin
               window   = 5'd16;
               cooldown = 6'd63;
               items    = 8'd255;
            end
            1: begin
               window   = 5'd1;
               cooldown = 6'd0;
               items    = 8'd0;
            end
            2: begin
               window   = 5'd0;
               cooldown = 6'($urandom_range(3));
               items    = 8'($urandom_range(6, 1));
            end
            default: begin
               window   = 5'($urandom_range(16));
               cooldown = ($urandom_range(4) == 0) ? 6'($urandom) : 6'($urandom_range(6));
               items    = $urandom_range(1) ? 8'($urandom) : 8'($urandom_range(8));
            end
         endcase
         left  = CODE_W'($urandom);
         right = ($urandom_range(5) == 0) ? left : CODE_W'($urandom);
         apply_settings(window, cooldown, items, left, right);

         case (phase % 4)
            0: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct   = 73;
               stall_pct = 0;
            end
            2: begin
               gap_pct   = 0;
               stall_pct = 73;
            end
            default: begin
               gap_pct   = 9;
               stall_pct = 9;
            end
         endcase
         // the result side holds off while frames keep coming until the block backs up
         if (phase == 4) hold_asks++;

         phase_frames = 0;
         while (phase_frames < PHASE_FRAMES) begin
            if ($urandom_range(3) != 0) push_gesture();
            else push_noise();
         end
         drain_results();
         gap_pct   = 0;
         stall_pct = 0;
      end

      if (mismatches == 0 && expected_left == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
